@@ rtl/sptmq_pkg.sv @@
// shared types, constants and codes of the strict priority timed message queue
// no dependencies
package sptmq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int TIME_BITS_DEF   = 16;
  localparam int NUM_LEVELS      = 3;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  level;
    logic [15:0] message_id;
    logic [15:0] display_time;
    logic [15:0] elapsed;
  } req_t;

  typedef struct packed {
    logic [15:0] current_message;
    logic        displaying;
    logic [15:0] time_left;
    logic        dropped;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

@@ rtl/strict_priority_timed_message_queue_core.sv @@
// top level of the strict priority timed message queue
// depends on sptmq_pkg, sptmq_ctrl, sptmq_datapath (and sptmq_ram below it)
//
// A request is taken when start is high and busy is low and executes in the
// following ST_EXEC state; its result appears on rsp_o with result_valid_o
// high for exactly one cycle right after. No new request is taken in
// ST_EXEC, which covers the registered read of the queue rams; they always
// present the head entry of each queue. The receiver cannot stall: every
// result must be captured in its strobe cycle. Queue storage is not cleared
// at reset; head and fill pointers, current message, timer and strobe are.
module strict_priority_timed_message_queue_core #(
  parameter int QUEUE_DEPTH = sptmq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = sptmq_pkg::TIME_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  sptmq_pkg::req_t req_i,
  output logic            result_valid_o,
  output sptmq_pkg::rsp_t rsp_o
);

  sptmq_pkg::cmd_t cmd;

  sptmq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  sptmq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> result_valid_o && !busy)
    else $error("execution cycle not followed by a result");

  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a preceding execution cycle");

endmodule

@@ rtl/sptmq_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module sptmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/sptmq_ctrl.sv @@
// controller state machine: accepts a request and schedules its execution
// depends on sptmq_pkg
module sptmq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output sptmq_pkg::cmd_t   cmd_o
);

  sptmq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sptmq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sptmq_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = sptmq_pkg::ST_EXEC;
        end
      end
      sptmq_pkg::ST_EXEC: begin
        state_d = sptmq_pkg::ST_IDLE;
      end
      default: begin
        state_d = sptmq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    unique case (state_q)
      sptmq_pkg::ST_IDLE: begin
        cmd_o.load = start_i;
      end
      sptmq_pkg::ST_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/sptmq_datapath.sv @@
// datapath: three priority queues in ram, head and fill pointers, display timer
// depends on sptmq_pkg and sptmq_ram
module sptmq_datapath #(
  parameter int QUEUE_DEPTH = sptmq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = sptmq_pkg::TIME_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sptmq_pkg::cmd_t   cmd_i,
  input  sptmq_pkg::req_t   req_i,
  output logic              result_valid_o,
  output sptmq_pkg::rsp_t   rsp_o
);

  localparam int NL      = sptmq_pkg::NUM_LEVELS;
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = PTR_W + 2;
  localparam int ENTRY_W = 16 + TIME_BITS;

  function automatic logic [TIME_BITS-1:0] to_time(input logic [15:0] v);
    logic [TIME_BITS+15:0] w;
    w = {{TIME_BITS{1'b0}}, v};
    return w[TIME_BITS-1:0];
  endfunction

  function automatic logic [15:0] to_out(input logic [TIME_BITS-1:0] v);
    logic [TIME_BITS+15:0] w;
    w = {16'b0, v};
    return w[15:0];
  endfunction

  sptmq_pkg::req_t      req_q;
  logic [PTR_W-1:0]     head_q [NL];
  logic [PTR_W-1:0]     head_d [NL];
  logic [CNT_W-1:0]     fill_q [NL];
  logic [CNT_W-1:0]     fill_d [NL];
  logic [PTR_W-1:0]     tail   [NL];
  logic [PTR_W-1:0]     head_nx [NL];
  logic [ENTRY_W-1:0]   rd_data [NL];
  logic [NL-1:0]        wr_en;
  logic [ENTRY_W-1:0]   wr_data;
  logic [15:0]          cur_q, cur_d;
  logic [TIME_BITS-1:0] rem_q, rem_d;
  logic [TIME_BITS-1:0] rem_dec;
  logic [TIME_BITS-1:0] elapsed_t;
  logic                 dropped;
  logic                 popped;
  logic                 result_valid_q;
  sptmq_pkg::rsp_t      rsp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head_q[l]) + SUM_W'(fill_q[l]);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
        sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      tail[l]    = sum[PTR_W-1:0];
      head_nx[l] = (head_q[l] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q[l] + PTR_W'(1);
    end
  end

  assign wr_data   = {req_q.message_id, to_time(req_q.display_time)};
  assign elapsed_t = to_time(req_q.elapsed);
  assign rem_dec   = (rem_q > elapsed_t) ? rem_q - elapsed_t : '0;

  always_comb begin
    wr_en   = '0;
    dropped = 1'b0;
    popped  = 1'b0;
    cur_d   = cur_q;
    rem_d   = rem_q;
    for (int l = 0; l < NL; l++) begin
      head_d[l] = head_q[l];
      fill_d[l] = fill_q[l];
    end
    if (cmd_i.exec) begin
      unique case (req_q.mode)
        sptmq_pkg::MODE_ADD: begin
          dropped = 1'b1;
          for (int l = 0; l < NL; l++) begin
            if (req_q.level == 2'(l) && fill_q[l] != CNT_W'(QUEUE_DEPTH)) begin
              dropped   = 1'b0;
              wr_en[l]  = 1'b1;
              fill_d[l] = fill_q[l] + CNT_W'(1);
            end
          end
        end
        sptmq_pkg::MODE_TICK: begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            cur_d = '0;
            for (int l = 0; l < NL; l++) begin
              if (!popped && fill_q[l] != '0) begin
                popped    = 1'b1;
                cur_d     = rd_data[l][ENTRY_W-1 -: 16];
                rem_d     = rd_data[l][TIME_BITS-1:0];
                head_d[l] = head_nx[l];
                fill_d[l] = fill_q[l] - CNT_W'(1);
              end
            end
          end
        end
        sptmq_pkg::MODE_CLEAR: begin
          cur_d = '0;
          rem_d = '0;
          for (int l = 0; l < NL; l++) begin
            head_d[l] = '0;
            fill_d[l] = '0;
          end
        end
        default: begin
          cur_d = cur_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q          <= '0;
      rem_q          <= '0;
      result_valid_q <= 1'b0;
      for (int l = 0; l < NL; l++) begin
        head_q[l] <= '0;
        fill_q[l] <= '0;
      end
    end else begin
      cur_q          <= cur_d;
      rem_q          <= rem_d;
      result_valid_q <= cmd_i.exec;
      for (int l = 0; l < NL; l++) begin
        head_q[l] <= head_d[l];
        fill_q[l] <= fill_d[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_q.current_message <= cur_d;
      rsp_q.displaying      <= (rem_d != '0) && (cur_d != '0);
      rsp_q.time_left       <= to_out(rem_d);
      rsp_q.dropped         <= dropped;
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_queue
    sptmq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk_i     (clk_i),
      .wr_en_i   (wr_en[g]),
      .wr_addr_i (tail[g]),
      .wr_data_i (wr_data),
      .rd_addr_i (head_q[g]),
      .rd_data_o (rd_data[g])
    );
  end

  assign result_valid_o = result_valid_q;
  assign rsp_o          = rsp_q;

  for (genvar g = 0; g < NL; g++) begin : g_chk
    a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      fill_q[g] <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");
  end

  a_drop_only_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropped |-> cmd_i.exec && req_q.mode == sptmq_pkg::MODE_ADD)
    else $error("drop flagged outside an add");

endmodule
